// File: design/gbce_pkg.sv
package gbce_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;

  localparam logic [2:0] MODE_LEFT   = 3'd0;
  localparam logic [2:0] MODE_RIGHT  = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_INSERT = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BOUNDARY = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] symbol;
    logic [9:0] position;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [10:0] text_length;
    logic [1:0]  status;
  } result_t;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic finish;
  } ctl_t;

endpackage

// File: design/gbce_ram.sv
module gbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/gbce_ctrl.sv
module gbce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output gbce_pkg::ctl_t ctl
);

  gbce_pkg::state_t state;
  gbce_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbce_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gbce_pkg::S_IDLE: begin
        if (start) begin
          state_next = gbce_pkg::S_FINISH;
        end
      end
      gbce_pkg::S_FINISH: begin
        state_next = gbce_pkg::S_IDLE;
      end
      default: begin
        state_next = gbce_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    ctl.load   = 1'b0;
    ctl.finish = 1'b0;
    unique case (state)
      gbce_pkg::S_IDLE: begin
        ctl.load = start;
      end
      gbce_pkg::S_FINISH: begin
        busy       = 1'b1;
        ctl.finish = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// File: design/gbce_dp.sv
module gbce_dp (
  input  logic             clk,
  input  logic             rst,
  input  gbce_pkg::ctl_t   ctl,
  input  gbce_pkg::cmd_t   cmd,
  output logic             done,
  output gbce_pkg::result_t result
);

  localparam int AW = gbce_pkg::ADDR_W;
  localparam int CW = gbce_pkg::CNT_W;

  gbce_pkg::cmd_t    cmd_q;
  logic [CW-1:0]     left_cnt;
  logic [CW-1:0]     right_cnt;
  logic [CW-1:0]     left_cnt_next;
  logic [CW-1:0]     right_cnt_next;
  gbce_pkg::result_t result_next;

  logic [AW-1:0] top_addr;
  logic [AW-1:0] read_addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          we;
  logic [CW-1:0] total;

  // Entry of the first character after the cursor.
  assign top_addr = AW'(CW'(gbce_pkg::CAPACITY) - right_cnt);
  assign total    = left_cnt + right_cnt;

  always_comb begin
    if (CW'(cmd.position) < left_cnt) begin
      read_addr = AW'(cmd.position);
    end else begin
      read_addr = top_addr + AW'(CW'(cmd.position) - left_cnt);
    end
  end

  // The store is read while the transaction is accepted, so its data is
  // ready in the finishing cycle.
  always_comb begin
    unique case (cmd.mode)
      gbce_pkg::MODE_LEFT:  raddr = AW'(left_cnt - CW'(1));
      gbce_pkg::MODE_RIGHT: raddr = top_addr;
      default:              raddr = read_addr;
    endcase
  end

  gbce_ram #(
    .WIDTH(8),
    .DEPTH(gbce_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    left_cnt_next      = left_cnt;
    right_cnt_next     = right_cnt;
    we                 = 1'b0;
    waddr              = AW'(left_cnt);
    wdata              = cmd_q.symbol;
    result_next.char_out = 8'd0;
    result_next.status   = gbce_pkg::ST_DONE;
    unique case (cmd_q.mode)
      gbce_pkg::MODE_LEFT: begin
        if (left_cnt == '0) begin
          result_next.status = gbce_pkg::ST_BOUNDARY;
        end else begin
          we             = ctl.finish;
          waddr          = top_addr - AW'(1);
          wdata          = rdata;
          left_cnt_next  = left_cnt - CW'(1);
          right_cnt_next = right_cnt + CW'(1);
        end
      end
      gbce_pkg::MODE_RIGHT: begin
        if (right_cnt == '0) begin
          result_next.status = gbce_pkg::ST_BOUNDARY;
        end else begin
          we             = ctl.finish;
          wdata          = rdata;
          left_cnt_next  = left_cnt + CW'(1);
          right_cnt_next = right_cnt - CW'(1);
        end
      end
      gbce_pkg::MODE_DELETE: begin
        if (right_cnt == '0) begin
          result_next.status = gbce_pkg::ST_BOUNDARY;
        end else begin
          right_cnt_next = right_cnt - CW'(1);
        end
      end
      gbce_pkg::MODE_INSERT: begin
        if (total >= CW'(gbce_pkg::CAPACITY)) begin
          result_next.status = gbce_pkg::ST_FULL;
        end else begin
          we            = ctl.finish;
          left_cnt_next = left_cnt + CW'(1);
        end
      end
      gbce_pkg::MODE_READ: begin
        if (CW'(cmd_q.position) >= total) begin
          result_next.status = gbce_pkg::ST_RANGE;
        end else begin
          result_next.char_out = rdata;
        end
      end
      default: begin
        result_next.status = gbce_pkg::ST_BOUNDARY;
      end
    endcase
    result_next.text_length = 11'(left_cnt_next + right_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
    end
    if (ctl.finish) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cnt  <= '0;
      right_cnt <= '0;
      done      <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.finish) begin
        left_cnt  <= left_cnt_next;
        right_cnt <= right_cnt_next;
      end
    end
  end

endmodule

// File: design/gap_buffer_cursor_editor.sv
// Gap buffer line editor with a cursor.
// A command transaction (mode, symbol, position) is accepted on a rising
// edge with start high and busy low. Modes are move left, move right,
// delete after the cursor, insert before the cursor and read at a position.
// Each command produces exactly one result (char_out, text_length, status),
// shown on the result port while done is high for a single cycle. The result
// is registered at the end of the finishing cycle and taken at the next edge.
// A command reads the text store at the accepting edge, then writes it back
// and updates the counts at the end of the finishing cycle, since a cursor
// move reads an entry and copies it across the gap through the registered
// read port of the store. busy is high in the finishing cycle; a new command
// may be accepted after it, also in the cycle the previous result is shown.
// Reset clears the cursor counts, so the text is empty; the store contents
// are not cleared and no entry is read before it is written.
// The receiver cannot stall; each result must be taken in its cycle.
module gap_buffer_cursor_editor (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gbce_pkg::cmd_t    cmd,
  output logic              done,
  output gbce_pkg::result_t result
);

  gbce_pkg::ctl_t ctl;

  gbce_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .ctl  (ctl)
  );

  gbce_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("transaction did not finish after its second cycle");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.text_length <= 11'(gbce_pkg::CAPACITY)))
    else $error("text length beyond capacity");

endmodule
